// ===== src/qte_pkg.sv =====
`timescale 1ns / 1ps
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  // Widths of the datapath.
  localparam int SW = 35;   // product sums, units 2^-30
  localparam int CW = 38;   // CORDIC x and y, with room for the gain
  localparam int ZW = 20;   // CORDIC angle, units 2^-16 rad
  localparam int NW = 63;   // square root remainder and trial values
  localparam int RW = 31;   // square root result

  localparam logic signed [ZW-1:0] ANG_PI      = 20'sd205887;
  localparam logic signed [15:0]   Q13_PI      = 16'sd25736;
  localparam logic signed [15:0]   Q13_HALF_PI = 16'sd12868;

  // atan(2^-k) in units of 2^-16 rad, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_ent(input logic [4:0] k);
    logic signed [ZW-1:0] r;
    case (k)
      5'd0:    r = 20'sd51472;
      5'd1:    r = 20'sd30386;
      5'd2:    r = 20'sd16055;
      5'd3:    r = 20'sd8150;
      5'd4:    r = 20'sd4091;
      5'd5:    r = 20'sd2047;
      5'd6:    r = 20'sd1024;
      5'd7:    r = 20'sd512;
      5'd8:    r = 20'sd256;
      5'd9:    r = 20'sd128;
      5'd10:   r = 20'sd64;
      5'd11:   r = 20'sd32;
      5'd12:   r = 20'sd16;
      5'd13:   r = 20'sd8;
      5'd14:   r = 20'sd4;
      5'd15:   r = 20'sd2;
      5'd16:   r = 20'sd1;
      default: r = 20'sd0;
    endcase
    return r;
  endfunction

  // Round an angle in 2^-16 rad to Q2.13 and limit it to +-lim.
  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z,
                                               input logic signed [15:0] lim);
    logic signed [ZW:0] t;
    logic signed [ZW:0] r;
    logic signed [15:0] q;
    t = ($signed({z[ZW-1], z}) + 21'sd4) >>> 3;
    r = t;
    if (r > 21'(lim)) begin
      q = lim;
    end else if (r < -21'(lim)) begin
      q = -lim;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

endpackage

// ===== src/qte_isqrt.sv =====
`timescale 1ns / 1ps
module qte_isqrt #(
  parameter int PW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [qte_pkg::NW-3:0]    in_n,
  input  logic [PW-1:0]             in_pay,
  output logic                      out_valid,
  output logic [qte_pkg::RW-1:0]    out_root,
  output logic [PW-1:0]             out_pay
);
  import qte_pkg::*;

  localparam int STEPS = NW / 2 + 1;

  logic [NW-1:0] rem [0:STEPS];
  logic [NW-1:0] res [0:STEPS];
  logic [PW-1:0] pay [0:STEPS];
  logic          vld [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      rem[0] <= NW'(in_n);
      res[0] <= '0;
      pay[0] <= in_pay;
    end
  end

  // One result bit per stage, trial bit walking down from 2^62.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (NW - 1 - 2 * k);
    logic [NW-1:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        pay[k+1] <= pay[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_root  = res[STEPS][RW-1:0];
  assign out_pay   = pay[STEPS];

endmodule

// ===== src/qte_cordic.sv =====
`timescale 1ns / 1ps
module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF,
  parameter int TAG_W  = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [qte_pkg::CW-1:0] in_y,
  input  logic signed [qte_pkg::CW-1:0] in_x,
  input  logic [TAG_W-1:0]              in_tag,
  output logic                          out_valid,
  output logic signed [qte_pkg::ZW-1:0] out_ang,
  output logic [TAG_W-1:0]              out_tag
);
  import qte_pkg::*;

  logic signed [CW-1:0] xs [0:STAGES];
  logic signed [CW-1:0] ys [0:STAGES];
  logic signed [ZW-1:0] zs [0:STAGES];
  logic                 zr [0:STAGES];
  logic [TAG_W-1:0]     tg [0:STAGES];
  logic                 vl [0:STAGES];

  // Pre-rotation by +-pi folds the left half plane into the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= in_valid;
    end
    if (en) begin
      zr[0] <= (in_x == '0) && (in_y == '0);
      tg[0] <= in_tag;
      if (in_x < 0) begin
        xs[0] <= -in_x;
        ys[0] <= -in_y;
        zs[0] <= (in_y >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        xs[0] <= in_x;
        ys[0] <= in_y;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
      if (en) begin
        zr[i+1] <= zr[i];
        tg[i+1] <= tg[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + atan_ent(5'(i));
        end else begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - atan_ent(5'(i));
        end
      end
    end
  end

  assign out_valid = vl[STAGES];
  assign out_ang   = zr[STAGES] ? '0 : zs[STAGES];
  assign out_tag   = tg[STAGES];

endmodule

// ===== src/quaternion_to_euler_zyx.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload
// s_axis   in   tdata[63:0]: quat_w, quat_x, quat_y, quat_z (16 bits each)
// m_axis   out  tdata[47:0]: roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One item enters per cycle while the pipeline is not stalled; an item passes
// through the three product/sum stages, the square root pipeline, the CORDIC
// pipeline and the output register, in that order.
// The whole pipeline advances on one enable: it moves whenever the output
// register is empty or being taken, so a stall freezes every stage in place.
// Synchronous reset clears only the valid bits.
module quaternion_to_euler_zyx #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle, pitch_clamped
);
  import qte_pkg::*;

  localparam int PAY_W = 5 * SW + 2;
  localparam logic signed [SW-1:0] ONE_Q30 = SW'(1) <<< 30;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Products.
  logic v1;
  logic signed [31:0] wx, yz, xx, yy, wy, zx, wz, xy, zz;
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      wx <= qw * qx;
      yz <= qy * qz;
      xx <= qx * qx;
      yy <= qy * qy;
      wy <= qw * qy;
      zx <= qz * qx;
      wz <= qw * qz;
      xy <= qx * qy;
      zz <= qz * qz;
    end
  end

  // Sine and cosine terms, units 2^-30.
  logic v2;
  logic signed [SW-1:0] sr2, cr2, sp2, sy2, cy2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      sr2 <= (SW'(wx) + SW'(yz)) <<< 1;
      cr2 <= ONE_Q30 - ((SW'(xx) + SW'(yy)) <<< 1);
      sp2 <= (SW'(wy) - SW'(zx)) <<< 1;
      sy2 <= (SW'(wz) + SW'(xy)) <<< 1;
      cy2 <= ONE_Q30 - ((SW'(yy) + SW'(zz)) <<< 1);
    end
  end

  // Radicand 1 - s*s for the pitch cosine.
  logic v3;
  logic [NW-3:0] n3;
  logic [PAY_W-1:0] pay3;
  logic signed [SW-1:0] spmag;
  logic [29:0] a30;
  logic [59:0] sq;
  logic clamp2;
  assign spmag  = (sp2 < 0) ? -sp2 : sp2;
  assign a30    = spmag[29:0];
  assign sq     = 60'(a30) * 60'(a30);
  assign clamp2 = (sp2 >= ONE_Q30) || (sp2 <= -ONE_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      n3   <= (61'(1) << 60) - 61'(sq);
      pay3 <= {sr2, cr2, sp2, sy2, cy2, clamp2, (sp2 > 0)};
    end
  end

  logic v4;
  logic [RW-1:0] root4;
  logic [PAY_W-1:0] pay4;
  qte_isqrt #(.PW(PAY_W)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .in_n     (n3),
    .in_pay   (pay3),
    .out_valid(v4),
    .out_root (root4),
    .out_pay  (pay4)
  );

  logic signed [SW-1:0] sr4, cr4, sp4, sy4, cy4;
  logic [1:0] ptag4;
  assign {sr4, cr4, sp4, sy4, cy4, ptag4} = pay4;

  logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;
  logic v5;
  logic [1:0] ptag5;

  qte_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(2)) u_pitch (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .in_y     (CW'(sp4)),
    .in_x     ($signed(CW'(root4))),
    .in_tag   (ptag4),
    .out_valid(v5),
    .out_ang  (pitch_z),
    .out_tag  (ptag5)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(1)) u_roll (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .in_y     (CW'(sr4)),
    .in_x     (CW'(cr4)),
    .in_tag   (1'b0),
    .out_valid(),
    .out_ang  (roll_z),
    .out_tag  ()
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(1)) u_yaw (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .in_y     (CW'(sy4)),
    .in_x     (CW'(cy4)),
    .in_tag   (1'b0),
    .out_valid(),
    .out_ang  (yaw_z),
    .out_tag  ()
  );

  // Output register.
  logic signed [15:0] pitch_q;
  logic signed [15:0] pitch_sel;
  assign pitch_q   = to_q13(pitch_z, Q13_HALF_PI);
  assign pitch_sel = ptag5[1] ? (ptag5[0] ? Q13_HALF_PI : -Q13_HALF_PI) : pitch_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v5;
    end
    if (en) begin
      m_tdata <= {ptag5[1], to_q13(yaw_z, Q13_PI), pitch_sel[14:0],
                  to_q13(roll_z, Q13_PI)};
    end
  end

  logic signed [15:0] roll_o, yaw_o;
  logic signed [14:0] pitch_o;
  assign roll_o  = m_tdata[15:0];
  assign pitch_o = m_tdata[30:16];
  assign yaw_o   = m_tdata[46:31];

  a_clamp_pitch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[47] |-> (pitch_o == 15'sd12868) || (pitch_o == -15'sd12868))
    else $error("forced pitch is not a quarter turn");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pitch_o <= 15'sd12868) && (pitch_o >= -15'sd12868))
    else $error("pitch out of range");

  a_roll_yaw_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (roll_o <= 16'sd25736) && (roll_o >= -16'sd25736) &&
                 (yaw_o <= 16'sd25736) && (yaw_o >= -16'sd25736))
    else $error("roll or yaw out of range");

endmodule
